// ===== src/acfb_pkg.sv =====
package acfb_pkg;

  localparam int SEC0_LEN = 8;
  localparam int SEC1_LEN = 8;
  localparam int SEC2_LEN = 19;

  localparam logic [1:0] SEC_0 = 2'd0;
  localparam logic [1:0] SEC_1 = 2'd1;
  localparam logic [1:0] SEC_2 = 2'd2;

  // Register map indexes
  localparam logic [1:0] REG_MIN_F = 2'd0;
  localparam logic [1:0] REG_MAX_F = 2'd1;
  localparam logic [1:0] REG_MIN_C = 2'd2;
  localparam logic [1:0] REG_MAX_C = 2'd3;

  localparam logic [7:0] RST_MIN_F = 8'd64;
  localparam logic [7:0] RST_MAX_F = 8'd90;
  localparam logic [7:0] RST_MIN_C = 8'd18;
  localparam logic [7:0] RST_MAX_C = 8'd32;

  // Operating modes
  localparam logic [2:0] MODE_AUTO = 3'd0;
  localparam logic [2:0] MODE_DRY  = 3'd1;
  localparam logic [2:0] MODE_COOL = 3'd2;
  localparam logic [2:0] MODE_HEAT = 3'd3;
  localparam logic [2:0] MODE_FAN  = 3'd4;

  // Fan speed codes
  localparam logic [2:0] FAN_SPD1  = 3'd0;
  localparam logic [2:0] FAN_SPD2  = 3'd1;
  localparam logic [2:0] FAN_SPD3  = 3'd2;
  localparam logic [2:0] FAN_SPD4  = 3'd3;
  localparam logic [2:0] FAN_SPD5  = 3'd4;
  localparam logic [2:0] FAN_AUTO  = 3'd5;
  localparam logic [2:0] FAN_NIGHT = 3'd6;

  // Sensor select codes
  localparam logic [1:0] SENS_OFF     = 2'd0;
  localparam logic [1:0] SENS_EYE     = 2'd1;
  localparam logic [1:0] SENS_COMFORT = 2'd2;
  localparam logic [1:0] SENS_BOTH    = 2'd3;

  // Result status codes
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  localparam logic [7:0] SEC0_BASE [SEC0_LEN] =
    '{8'h11, 8'hDA, 8'h27, 8'h00, 8'hC5, 8'h00, 8'h00, 8'hD7};
  localparam logic [7:0] SEC1_BASE [SEC1_LEN] =
    '{8'h11, 8'hDA, 8'h27, 8'h00, 8'h42, 8'h00, 8'h10, 8'h64};

  localparam logic [7:0] COMFORT_B6 = 8'h10;
  localparam logic [7:0] DRY_TEMP   = 8'hC0;
  localparam logic [7:0] FAN_TEMP   = 8'h32;
  localparam logic [7:0] FAN_CODE_A = 8'hA0;
  localparam logic [7:0] EYE_ON     = 8'h82;
  localparam logic [7:0] EYE_OFF    = 8'h80;
  localparam logic [7:0] S2_B11     = 8'h06;
  localparam logic [7:0] S2_B12     = 8'h60;
  localparam logic [7:0] S2_B15     = 8'hC1;
  localparam logic [7:0] QUIET_ON   = 8'h20;
  localparam logic [7:0] SWING_ON   = 8'h0F;
  localparam logic [7:0] TEMP_BIAS  = 8'd28;
  localparam logic [7:0] FAHR_BASE  = 8'd32;
  // floor(x/5) == (x*DIV5_RECIP) >> DIV5_SHIFT for x < 2**DIV5_SHIFT
  localparam logic [11:0] DIV5_RECIP = 12'd3277;
  localparam int          DIV5_SHIFT = 14;

  typedef struct packed {
    logic       power_on;
    logic [2:0] op_mode;
    logic       fahrenheit_sel;
    logic [7:0] target_f;
    logic [7:0] target_c;
    logic [2:0] fan_speed;
    logic [1:0] sensor_sel;
    logic       swing_vert;
    logic       swing_horiz;
    logic       quiet_on;
  } acfb_req_t;

  typedef struct packed {
    logic       status;
    logic [1:0] section_num;
    logic [4:0] byte_pos;
    logic [7:0] frame_byte;
    logic       last_byte;
  } acfb_res_t;

  typedef struct packed {
    logic [7:0] min_temp_f;
    logic [7:0] max_temp_f;
    logic [7:0] min_temp_c;
    logic [7:0] max_temp_c;
  } acfb_cfg_t;

  typedef struct packed {
    logic       capture;
    logic       emit;
    logic [1:0] sec;
    logic [4:0] pos;
    logic       last;
  } acfb_cmd_t;

  typedef struct packed {
    logic bad;
  } acfb_sts_t;

endpackage

// ===== src/acfb_if.sv =====
interface acfb_in_if;
  logic       valid;
  logic       ready;
  logic       power_on;
  logic [2:0] op_mode;
  logic       fahrenheit_sel;
  logic [7:0] target_f;
  logic [7:0] target_c;
  logic [2:0] fan_speed;
  logic [1:0] sensor_sel;
  logic       swing_vert;
  logic       swing_horiz;
  logic       quiet_on;

  modport source (
    output valid, power_on, op_mode, fahrenheit_sel, target_f, target_c,
           fan_speed, sensor_sel, swing_vert, swing_horiz, quiet_on,
    input  ready
  );
  modport sink (
    input  valid, power_on, op_mode, fahrenheit_sel, target_f, target_c,
           fan_speed, sensor_sel, swing_vert, swing_horiz, quiet_on,
    output ready
  );
endinterface

interface acfb_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [1:0] section_num;
  logic [4:0] byte_pos;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (
    output valid, status, section_num, byte_pos, frame_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, status, section_num, byte_pos, frame_byte, last_byte,
    output ready
  );
endinterface

// ===== src/acfb_cfg_regs.sv =====
module acfb_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output acfb_pkg::acfb_cfg_t cfg
);
  import acfb_pkg::*;

  acfb_cfg_t cfg_r;
  acfb_cfg_t cfg_nxt;
  logic      wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_MIN_F: cfg_nxt.min_temp_f = pwdata[7:0];
        REG_MAX_F: cfg_nxt.max_temp_f = pwdata[7:0];
        REG_MIN_C: cfg_nxt.min_temp_c = pwdata[7:0];
        REG_MAX_C: cfg_nxt.max_temp_c = pwdata[7:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_F: prdata = {24'd0, cfg_r.min_temp_f};
      REG_MAX_F: prdata = {24'd0, cfg_r.max_temp_f};
      REG_MIN_C: prdata = {24'd0, cfg_r.min_temp_c};
      REG_MAX_C: prdata = {24'd0, cfg_r.max_temp_c};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_temp_f <= RST_MIN_F;
      cfg_r.max_temp_f <= RST_MAX_F;
      cfg_r.min_temp_c <= RST_MIN_C;
      cfg_r.max_temp_c <= RST_MAX_C;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/acfb_ctrl.sv =====
module acfb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  acfb_pkg::acfb_sts_t sts,
  output acfb_pkg::acfb_cmd_t cmd
);
  import acfb_pkg::*;

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  state_t     state_r, state_nxt;
  logic [1:0] sec_r, sec_nxt;
  logic [4:0] pos_r, pos_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       sec_end;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    in_ready = (state_r == S_IDLE);

    case (sec_r)
      SEC_0:   sec_end = (pos_r == 5'(SEC0_LEN - 1));
      SEC_1:   sec_end = (pos_r == 5'(SEC1_LEN - 1));
      default: sec_end = (pos_r == 5'(SEC2_LEN - 1));
    endcase

    cmd.capture = in_valid && in_ready;
    cmd.emit    = (state_r == S_EMIT) && out_free;
    cmd.sec     = sec_r;
    cmd.pos     = pos_r;
    cmd.last    = sts.bad || (sec_r == SEC_2 && sec_end);

    state_nxt = state_r;
    sec_nxt   = sec_r;
    pos_nxt   = pos_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EMIT;
          sec_nxt   = SEC_0;
          pos_nxt   = 5'd0;
        end
      end
      S_EMIT: begin
        if (cmd.emit) begin
          if (cmd.last) begin
            state_nxt = S_IDLE;
          end else if (sec_end) begin
            sec_nxt = sec_r + 2'd1;
            pos_nxt = 5'd0;
          end else begin
            pos_nxt = pos_r + 5'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sec_r       <= SEC_0;
      pos_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sec_r       <= sec_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_capture_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_EMIT && sec_r == SEC_0 && pos_r == 5'd0))
    else $error("capture did not start a frame");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == S_IDLE && out_valid_r))
    else $error("final byte did not return to idle");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sec_r != 2'd3) && (pos_r <= 5'(SEC2_LEN - 1)))
    else $error("byte counter out of range");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !cmd.emit)
    else $error("emit while idle");

endmodule

// ===== src/acfb_dp.sv =====
module acfb_dp (
  input  logic                clk,
  input  acfb_pkg::acfb_req_t req,
  input  acfb_pkg::acfb_cfg_t cfg,
  input  acfb_pkg::acfb_cmd_t cmd,
  output acfb_pkg::acfb_sts_t sts,
  output acfb_pkg::acfb_res_t res
);
  import acfb_pkg::*;

  acfb_req_t req_r;
  logic      bad_r, bad_nxt;
  logic [7:0] sum_r, sum_nxt;
  acfb_res_t res_r, res_nxt;

  logic        comfort;
  logic        eye;
  logic [11:0] tc_x9;
  logic [23:0] div_prod;
  logic [7:0]  temp_byte;
  logic [7:0]  mode_code;
  logic [7:0]  fan_code;
  logic [7:0]  s2_byte;
  logic [7:0]  cur_byte;

  always_comb begin
    if (req.fahrenheit_sel) begin
      bad_nxt = (req.target_f < cfg.min_temp_f) || (req.target_f > cfg.max_temp_f);
    end else begin
      bad_nxt = (req.target_c < cfg.min_temp_c) || (req.target_c > cfg.max_temp_c);
    end
  end

  always_comb begin
    comfort = req_r.sensor_sel[1];
    eye     = req_r.sensor_sel[0];

    // Celsius to Fahrenheit: c*9/5, divide by 5 through reciprocal multiply
    tc_x9    = {1'b0, req_r.target_c, 3'b000} + {4'd0, req_r.target_c};
    div_prod = tc_x9 * DIV5_RECIP;

    if (req_r.op_mode == MODE_DRY) begin
      temp_byte = DRY_TEMP;
    end else if (req_r.op_mode == MODE_FAN) begin
      temp_byte = FAN_TEMP;
    end else if (req_r.fahrenheit_sel) begin
      temp_byte = req_r.target_f - TEMP_BIAS;
    end else begin
      temp_byte = div_prod[DIV5_SHIFT +: 8] + FAHR_BASE - TEMP_BIAS;
    end

    case (req_r.op_mode)
      MODE_AUTO: mode_code = 8'h08;
      MODE_DRY:  mode_code = 8'h28;
      MODE_HEAT: mode_code = 8'h48;
      MODE_FAN:  mode_code = 8'h68;
      default:   mode_code = 8'h38;
    endcase
    mode_code[0] = req_r.power_on;

    if (req_r.op_mode == MODE_DRY) begin
      fan_code = FAN_CODE_A;
    end else begin
      case (req_r.fan_speed)
        FAN_SPD1:  fan_code = 8'h30;
        FAN_SPD2:  fan_code = 8'h40;
        FAN_SPD4:  fan_code = 8'h60;
        FAN_SPD5:  fan_code = 8'h70;
        FAN_AUTO:  fan_code = FAN_CODE_A;
        FAN_NIGHT: fan_code = 8'hB0;
        default:   fan_code = 8'h50;
      endcase
    end
    if (comfort) fan_code = FAN_CODE_A;
    if (req_r.swing_vert) fan_code = fan_code | SWING_ON;

    case (cmd.pos)
      5'd0:    s2_byte = SEC0_BASE[0];
      5'd1:    s2_byte = SEC0_BASE[1];
      5'd2:    s2_byte = SEC0_BASE[2];
      5'd5:    s2_byte = mode_code;
      5'd6:    s2_byte = temp_byte;
      5'd8:    s2_byte = fan_code;
      5'd9:    s2_byte = req_r.swing_horiz ? SWING_ON : 8'h00;
      5'd11:   s2_byte = S2_B11;
      5'd12:   s2_byte = S2_B12;
      5'd13:   s2_byte = req_r.quiet_on ? QUIET_ON : 8'h00;
      5'd15:   s2_byte = S2_B15;
      5'd16:   s2_byte = eye ? EYE_ON : EYE_OFF;
      5'd18:   s2_byte = sum_r;
      default: s2_byte = 8'h00;
    endcase

    case (cmd.sec)
      SEC_0: begin
        if (cmd.pos == 5'(SEC0_LEN - 1)) begin
          cur_byte = sum_r;
        end else if (cmd.pos == 5'd6 && comfort) begin
          cur_byte = COMFORT_B6;
        end else begin
          cur_byte = SEC0_BASE[cmd.pos[2:0]];
        end
      end
      SEC_1:   cur_byte = SEC1_BASE[cmd.pos[2:0]];
      default: cur_byte = s2_byte;
    endcase

    sum_nxt = (cmd.pos == 5'd0) ? cur_byte : sum_r + cur_byte;

    if (bad_r) begin
      res_nxt.status      = ST_RANGE;
      res_nxt.section_num = SEC_0;
      res_nxt.byte_pos    = 5'd0;
      res_nxt.frame_byte  = 8'h00;
      res_nxt.last_byte   = 1'b1;
    end else begin
      res_nxt.status      = ST_OK;
      res_nxt.section_num = cmd.sec;
      res_nxt.byte_pos    = cmd.pos;
      res_nxt.frame_byte  = cur_byte;
      res_nxt.last_byte   = cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= req;
      bad_r <= bad_nxt;
    end
    if (cmd.emit) begin
      sum_r <= sum_nxt;
      res_r <= res_nxt;
    end
  end

  assign sts.bad = bad_r;
  assign res     = res_r;

endmodule

// ===== src/ac_remote_frame_builder_core.sv =====
// Climate remote frame builder.
// in_ch carries one request with the full set of climate settings (valid/ready).
// out_ch returns result transactions (valid/ready), one frame byte each, tagged
// with section number, byte position and a last_byte flag on the final one.
// The target temperature in the selected unit is checked against the limit
// registers when the request is taken; a failing request yields one transaction
// with status set. A passing one yields 35 bytes: two 8-byte sections and one
// 19-byte section, each closed by its byte-sum checksum.
// Timing: on acceptance the sequencer enters its emit state, and the output register
// then takes the first result; after that it gives one byte per cycle while
// out_ch.ready is high, through a single output register. in_ch.ready is high only
// between requests; the next request can be taken at the edge that takes the final
// byte, so a new request is never taken while a frame is still being produced.
// When out_ch.ready is low the output register holds its transaction and the
// sequencer waits. Reset (rst_n, synchronous) empties the output and loads the
// limit registers with 64/90 F and 18/32 C. Limits are written over the
// APB-style port, at byte addresses 0, 4, 8 and 12.
module ac_remote_frame_builder_core (
  input  logic        clk,
  input  logic        rst_n,
  acfb_in_if.sink     in_ch,
  acfb_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import acfb_pkg::*;

  acfb_cfg_t cfg;
  acfb_cmd_t cmd;
  acfb_sts_t sts;
  acfb_req_t req;
  acfb_res_t res;

  assign req.power_on       = in_ch.power_on;
  assign req.op_mode        = in_ch.op_mode;
  assign req.fahrenheit_sel = in_ch.fahrenheit_sel;
  assign req.target_f       = in_ch.target_f;
  assign req.target_c       = in_ch.target_c;
  assign req.fan_speed      = in_ch.fan_speed;
  assign req.sensor_sel     = in_ch.sensor_sel;
  assign req.swing_vert     = in_ch.swing_vert;
  assign req.swing_horiz    = in_ch.swing_horiz;
  assign req.quiet_on       = in_ch.quiet_on;

  assign out_ch.status      = res.status;
  assign out_ch.section_num = res.section_num;
  assign out_ch.byte_pos    = res.byte_pos;
  assign out_ch.frame_byte  = res.frame_byte;
  assign out_ch.last_byte   = res.last_byte;

  acfb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  acfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  acfb_dp u_dp (
    .clk (clk),
    .req (req),
    .cfg (cfg),
    .cmd (cmd),
    .sts (sts),
    .res (res)
  );

endmodule

// ===== tb/ac_remote_frame_builder_core_test.sv =====
`timescale 1ns / 100ps

module ac_remote_frame_builder_core_test;
  import acfb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 1500;   // result count that starts the long receiver hold-off
  localparam int HOLD_LEN    = 300;

  // op_mode / fan_speed codes outside the defined set
  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;
  localparam logic [2:0] FAN_RSVD   = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  acfb_in_if  in_ch ();
  acfb_out_if out_ch ();

  ac_remote_frame_builder_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the limit registers
  logic [7:0] lim_min_f = RST_MIN_F;
  logic [7:0] lim_max_f = RST_MAX_F;
  logic [7:0] lim_min_c = RST_MIN_C;
  logic [7:0] lim_max_c = RST_MAX_C;

  acfb_req_t request_q [$];
  acfb_res_t frame_q [$];
  acfb_req_t cur_req;
  bit        req_in_flight;
  bit        steady;
  bit        hold_done;
  int        errors;
  int        bytes_seen;
  int        hold_left;
  int        cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] byte_sum(input logic [7:0] b [], input int n);
    logic [7:0] s;
    s = 8'h00;
    for (int i = 0; i < n; i++) s = s + b[i];
    return s;
  endfunction

  // Expected result transactions for one accepted request
  task automatic predict_frame(input acfb_req_t r);
    logic [7:0] s0 [];
    logic [7:0] s2 [];
    logic [7:0] b;
    bit         comfort;
    bit         eye;
    bit         bad;
    int         cel;
    acfb_res_t  res;
    if (r.fahrenheit_sel)
      bad = (r.target_f < lim_min_f) || (r.target_f > lim_max_f);
    else
      bad = (r.target_c < lim_min_c) || (r.target_c > lim_max_c);
    if (bad) begin
      res = '{status: ST_RANGE, section_num: SEC_0, byte_pos: 5'd0, frame_byte: 8'h00,
              last_byte: 1'b1};
      frame_q.push_back(res);
      return;
    end
    comfort = (r.sensor_sel == SENS_COMFORT) || (r.sensor_sel == SENS_BOTH);
    eye     = (r.sensor_sel == SENS_EYE) || (r.sensor_sel == SENS_BOTH);

    s0 = new[SEC0_LEN];
    for (int i = 0; i < SEC0_LEN; i++) s0[i] = SEC0_BASE[i];
    if (comfort) begin
      s0[6] = COMFORT_B6;
      s0[SEC0_LEN-1] = byte_sum(s0, SEC0_LEN - 1);
    end

    s2 = new[SEC2_LEN];
    for (int i = 0; i < SEC2_LEN; i++) s2[i] = 8'h00;
    s2[0] = SEC0_BASE[0];
    s2[1] = SEC0_BASE[1];
    s2[2] = SEC0_BASE[2];

    case (r.op_mode)
      MODE_AUTO: b = 8'h08;
      MODE_DRY:  b = 8'h28;
      MODE_HEAT: b = 8'h48;
      MODE_FAN:  b = 8'h68;
      default:   b = 8'h38;
    endcase
    if (r.power_on) b[0] = 1'b1;
    s2[5] = b;

    if (r.op_mode == MODE_DRY) s2[6] = DRY_TEMP;
    else if (r.op_mode == MODE_FAN) s2[6] = FAN_TEMP;
    else if (r.fahrenheit_sel) s2[6] = r.target_f - TEMP_BIAS;
    else begin
      cel = int'(r.target_c) * 9 / 5 + int'(FAHR_BASE) - int'(TEMP_BIAS);
      s2[6] = cel[7:0];
    end

    if (r.op_mode == MODE_DRY) b = FAN_CODE_A;
    else begin
      case (r.fan_speed)
        FAN_SPD1:  b = 8'h30;
        FAN_SPD2:  b = 8'h40;
        FAN_SPD4:  b = 8'h60;
        FAN_SPD5:  b = 8'h70;
        FAN_AUTO:  b = FAN_CODE_A;
        FAN_NIGHT: b = 8'hB0;
        default:   b = 8'h50;
      endcase
    end
    if (comfort) b = FAN_CODE_A;
    if (r.swing_vert) b = b | SWING_ON;
    s2[8] = b;

    s2[9]  = r.swing_horiz ? SWING_ON : 8'h00;
    s2[11] = S2_B11;
    s2[12] = S2_B12;
    s2[13] = r.quiet_on ? QUIET_ON : 8'h00;
    s2[15] = S2_B15;
    s2[16] = eye ? EYE_ON : EYE_OFF;
    s2[SEC2_LEN-1] = byte_sum(s2, SEC2_LEN - 1);

    for (int i = 0; i < SEC0_LEN; i++) begin
      res = '{status: ST_OK, section_num: SEC_0, byte_pos: 5'(i), frame_byte: s0[i],
              last_byte: 1'b0};
      frame_q.push_back(res);
    end
    for (int i = 0; i < SEC1_LEN; i++) begin
      res = '{status: ST_OK, section_num: SEC_1, byte_pos: 5'(i), frame_byte: SEC1_BASE[i],
              last_byte: 1'b0};
      frame_q.push_back(res);
    end
    for (int i = 0; i < SEC2_LEN; i++) begin
      res = '{status: ST_OK, section_num: SEC_2, byte_pos: 5'(i), frame_byte: s2[i],
              last_byte: (i == SEC2_LEN - 1)};
      frame_q.push_back(res);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      {in_ch.power_on, in_ch.op_mode, in_ch.fahrenheit_sel, in_ch.target_f,
       in_ch.target_c, in_ch.fan_speed, in_ch.sensor_sel, in_ch.swing_vert,
       in_ch.swing_horiz, in_ch.quiet_on} <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_frame(cur_req);
        req_in_flight = 1'b0;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (request_q.size() != 0 && (steady || $urandom_range(99) >= 24)) begin
          cur_req = request_q.pop_front();
          req_in_flight = 1'b1;
          {in_ch.power_on, in_ch.op_mode, in_ch.fahrenheit_sel, in_ch.target_f,
           in_ch.target_c, in_ch.fan_speed, in_ch.sensor_sel, in_ch.swing_vert,
           in_ch.swing_horiz, in_ch.quiet_on} <= cur_req;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // frame byte monitor and receiver back-pressure
  always @(posedge clk) begin : frame_mon
    acfb_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (frame_q.size() == 0) begin
          $error("unexpected transaction: status %0h section %0d pos %0d byte %02h",
                 out_ch.status, out_ch.section_num, out_ch.byte_pos, out_ch.frame_byte);
          errors++;
        end else begin
          want = frame_q.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0h, got %0h", want.status, out_ch.status);
            errors++;
          end
          if (out_ch.section_num !== want.section_num) begin
            $error("section_num: expected %0d, got %0d", want.section_num, out_ch.section_num);
            errors++;
          end
          if (out_ch.byte_pos !== want.byte_pos) begin
            $error("byte_pos: expected %0d, got %0d", want.byte_pos, out_ch.byte_pos);
            errors++;
          end
          if (out_ch.frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %02h, got %02h", want.frame_byte, out_ch.frame_byte);
            errors++;
          end
          if (out_ch.last_byte !== want.last_byte) begin
            $error("last_byte: expected %0h, got %0h", want.last_byte, out_ch.last_byte);
            errors++;
          end
        end
        bytes_seen++;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 24);
      end
    end
  end

  // one long receiver hold-off, counted in cycles
  always @(posedge clk) begin : hold_ctl
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_seen >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MIN_F: lim_min_f = val;
      REG_MAX_F: lim_max_f = val;
      REG_MIN_C: lim_min_c = val;
      REG_MAX_C: lim_max_c = val;
      default:   ;
    endcase
  endtask

  task automatic set_limits(input logic [7:0] min_f, input logic [7:0] max_f,
                            input logic [7:0] min_c, input logic [7:0] max_c);
    cfg_write(REG_MIN_F, min_f);
    cfg_write(REG_MAX_F, max_f);
    cfg_write(REG_MIN_C, min_c);
    cfg_write(REG_MAX_C, max_c);
  endtask

  task automatic add_req(input int pwr, input logic [2:0] mode, input int fsel,
                         input logic [7:0] tf, input logic [7:0] tc, input logic [2:0] fan,
                         input logic [1:0] sensor, input int swv, input int swh,
                         input int quiet);
    acfb_req_t r;
    r = '{power_on: 1'(pwr), op_mode: mode, fahrenheit_sel: 1'(fsel), target_f: tf,
          target_c: tc, fan_speed: fan, sensor_sel: sensor, swing_vert: 1'(swv),
          swing_horiz: 1'(swh), quiet_on: 1'(quiet)};
    request_q.push_back(r);
  endtask

  // mostly in-range targets, the rest anywhere
  function automatic acfb_req_t rand_req();
    acfb_req_t  r;
    logic [7:0] lo;
    logic [7:0] hi;
    r.power_on       = 1'($urandom_range(1));
    r.op_mode        = 3'($urandom_range(7));
    r.fahrenheit_sel = 1'($urandom_range(1));
    r.target_f       = 8'($urandom_range(255));
    r.target_c       = 8'($urandom_range(255));
    r.fan_speed      = 3'($urandom_range(7));
    r.sensor_sel     = 2'($urandom_range(3));
    r.swing_vert     = 1'($urandom_range(1));
    r.swing_horiz    = 1'($urandom_range(1));
    r.quiet_on       = 1'($urandom_range(1));
    lo = r.fahrenheit_sel ? lim_min_f : lim_min_c;
    hi = r.fahrenheit_sel ? lim_max_f : lim_max_c;
    if (lo <= hi && $urandom_range(99) < 85) begin
      if (r.fahrenheit_sel) r.target_f = 8'($urandom_range(hi, lo));
      else r.target_c = 8'($urandom_range(hi, lo));
    end
    return r;
  endfunction

  task automatic wait_idle();
    while (request_q.size() != 0 || req_in_flight || frame_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    repeat (n) request_q.push_back(rand_req());
    wait_idle();
  endtask

  initial begin
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset limits: 64..90 F, 18..32 C
    add_req(1, MODE_AUTO,  0, 8'd0,   8'd18,  FAN_SPD1,  SENS_OFF,     0, 0, 0);
    add_req(0, MODE_DRY,   0, 8'd255, 8'd32,  FAN_SPD2,  SENS_OFF,     1, 0, 0);
    add_req(1, MODE_COOL,  1, 8'd64,  8'd0,   FAN_SPD3,  SENS_EYE,     0, 1, 0);
    add_req(1, MODE_HEAT,  1, 8'd90,  8'd255, FAN_SPD4,  SENS_COMFORT, 0, 0, 1);
    add_req(1, MODE_FAN,   0, 8'hAA,  8'd25,  FAN_SPD5,  SENS_BOTH,    1, 1, 1);
    add_req(1, MODE_RSVD5, 1, 8'd70,  8'd0,   FAN_AUTO,  SENS_OFF,     0, 0, 0);
    add_req(0, MODE_RSVD7, 0, 8'd0,   8'd20,  FAN_NIGHT, SENS_OFF,     0, 0, 1);
    add_req(1, MODE_COOL,  0, 8'd0,   8'd30,  FAN_RSVD,  SENS_OFF,     1, 0, 0);
    // dry with comfort sensing and both swings
    add_req(1, MODE_DRY,   1, 8'd80,  8'd0,   FAN_NIGHT, SENS_COMFORT, 1, 1, 0);
    // just or far outside the limits in the selected unit only, then exactly at the limits
    add_req(1, MODE_COOL,  1, 8'd63,  8'd25,  FAN_SPD1,  SENS_OFF,     0, 0, 0);
    add_req(1, MODE_COOL,  1, 8'd91,  8'd25,  FAN_SPD1,  SENS_OFF,     0, 0, 0);
    add_req(1, MODE_HEAT,  0, 8'd70,  8'd17,  FAN_AUTO,  SENS_EYE,     0, 0, 0);
    add_req(1, MODE_HEAT,  0, 8'd70,  8'd33,  FAN_AUTO,  SENS_EYE,     0, 0, 0);
    add_req(0, MODE_AUTO,  0, 8'd70,  8'd255, FAN_SPD3,  SENS_BOTH,    1, 1, 1);
    add_req(0, MODE_AUTO,  1, 8'd0,   8'd25,  FAN_SPD3,  SENS_BOTH,    1, 1, 1);
    add_req(0, MODE_HEAT,  0, 8'd255, 8'd32,  FAN_AUTO,  SENS_EYE,     1, 1, 1);
    add_req(1, MODE_AUTO,  1, 8'd90,  8'd18,  FAN_SPD5,  SENS_BOTH,    0, 1, 0);
    wait_idle();

    // random with reset limits; the receiver hold-off lands here
    run_random(80);

    // widest limits, no idling on either side
    set_limits(8'd0, 8'd255, 8'd0, 8'd255);
    steady = 1'b1;
    run_random(50);
    steady = 1'b0;

    // minimum above maximum: everything rejected
    set_limits(8'd255, 8'd0, 8'd255, 8'd0);
    run_random(20);

    // single accepted value per unit
    set_limits(8'd75, 8'd75, 8'd0, 8'd0);
    run_random(30);

    set_limits(8'd40, 8'd110, 8'd10, 8'd40);
    run_random(30);

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/acfb_pkg.sv
src/acfb_if.sv
src/acfb_cfg_regs.sv
src/acfb_ctrl.sv
src/acfb_dp.sv
src/ac_remote_frame_builder_core.sv
tb/ac_remote_frame_builder_core_test.sv
